[sv/calendar_clock_counter_macros.svh]
// assertion macros for the calendar clock counter
// used by calendar_clock_counter.sv; no other dependencies
`ifndef CALENDAR_CLOCK_COUNTER_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_MACROS_SVH

`ifndef ASSERT_OFF

`define CCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("calendar clock counter assertion failed");

`define CCC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("calendar clock counter forbidden condition");

`else

`define CCC_ASSERT(label, clk, rst, prop)

`define CCC_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[sv/ccc_pkg.sv]
// types, opcodes and calendar helpers for the calendar clock counter
// no dependencies
package ccc_pkg;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;
   localparam logic [1:0] OP_RUN  = 2'd3;

   localparam logic [7:0] SEC_LAST   = 8'd59;
   localparam logic [7:0] MIN_LAST   = 8'd59;
   localparam logic [7:0] HOUR_LAST  = 8'd23;
   localparam logic [7:0] MONTH_LAST = 8'd12;
   localparam logic [7:0] DAYS_LONG  = 8'd31;
   localparam logic [7:0] DAYS_SHORT = 8'd30;
   localparam logic [7:0] DAYS_FEB   = 8'd28;
   localparam logic [7:0] DAYS_LEAP  = 8'd29;

   // odd-factor divisibility: x*inv(d) mod 2^16 <= (2^16-1)/d exactly when d divides x
   localparam logic [15:0] INV_25  = 16'd23593;
   localparam logic [15:0] LIM_25  = 16'd2621;
   localparam logic [15:0] INV_125 = 16'd30933;
   localparam logic [15:0] LIM_125 = 16'd524;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] load_year;
      logic [7:0]  load_month;
      logic [7:0]  load_day;
      logic [7:0]  load_hour;
      logic [7:0]  load_minute;
      logic [7:0]  load_second;
   } req_type;

   typedef struct packed {
      logic [15:0] year_out;
      logic [7:0]  month_out;
      logic [7:0]  day_out;
      logic [7:0]  hour_out;
      logic [7:0]  minute_out;
      logic [7:0]  second_out;
      logic        running_out;
   } rsp_type;

   // 4000 = 32*125, 400 = 16*25, 100 = 4*25
   function automatic logic is_leap(input logic [15:0] year);
      logic [15:0] p25;
      logic [15:0] p125;
      logic        d25;
      logic        d125;
      p25  = year * INV_25;
      p125 = year * INV_125;
      d25  = (p25 <= LIM_25);
      d125 = (p125 <= LIM_125);
      if (year[4:0] == 5'd0 && d125) begin
         is_leap = 1'b0;
      end else if (year[3:0] == 4'd0 && d25) begin
         is_leap = 1'b1;
      end else if (year[1:0] == 2'd0 && d25) begin
         is_leap = 1'b0;
      end else begin
         is_leap = (year[1:0] == 2'd0);
      end
   endfunction

   function automatic logic [7:0] month_days(input logic [7:0] month, input logic leap);
      case (month)
         8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: begin
            month_days = DAYS_LONG;
         end
         8'd2: begin
            month_days = leap ? DAYS_LEAP : DAYS_FEB;
         end
         default: begin
            month_days = DAYS_SHORT;
         end
      endcase
   endfunction

endpackage

[sv/calendar_clock_counter.sv]
// calendar clock counter: time-of-day and date registers with run flag
// depends on ccc_pkg and calendar_clock_counter_macros.svh
// a word accepted on req is held in the input register, then its result in the result register for rsp
// throughput: one word per cycle unless a stalled rsp holds the result register
// reset (synchronous, active high) clears all counters to zero and stops the clock
`include "calendar_clock_counter_macros.svh"

module calendar_clock_counter (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ccc_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ccc_pkg::rsp_type rsp_data
);
   import ccc_pkg::*;

   logic        in_valid_ff, in_valid_in;
   req_type     in_word_ff;

   logic [7:0]  sec_ff,   sec_in;
   logic [7:0]  min_ff,   min_in;
   logic [7:0]  hour_ff,  hour_in;
   logic [7:0]  day_ff,   day_in;
   logic [7:0]  month_ff, month_in;
   logic [15:0] year_ff,  year_in;
   logic        run_ff,   run_in;

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_word_ff,  out_word_in;

   logic        advance;
   logic        in_take;
   logic [7:0]  day_limit;

   // the update stage moves when it holds a word and the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_take   = req_valid && req_ready;

   assign in_valid_in  = in_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign day_limit = month_days(month_ff, is_leap(year_ff));

   always_comb begin
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      run_in   = run_ff;
      if (advance) begin
         case (in_word_ff.opcode)
            OP_TICK: begin
               if (run_ff) begin
                  // ripple the carry up through the counters
                  if (sec_ff < SEC_LAST) begin
                     sec_in = sec_ff + 8'd1;
                  end else begin
                     sec_in = 8'd0;
                     if (min_ff < MIN_LAST) begin
                        min_in = min_ff + 8'd1;
                     end else begin
                        min_in = 8'd0;
                        if (hour_ff < HOUR_LAST) begin
                           hour_in = hour_ff + 8'd1;
                        end else begin
                           hour_in = 8'd0;
                           if (day_ff < day_limit) begin
                              day_in = day_ff + 8'd1;
                           end else begin
                              day_in = 8'd1;
                              if (month_ff < MONTH_LAST) begin
                                 month_in = month_ff + 8'd1;
                              end else begin
                                 month_in = 8'd1;
                                 year_in  = year_ff + 16'd1;
                              end
                           end
                        end
                     end
                  end
               end
            end
            OP_LOAD: begin
               year_in  = in_word_ff.load_year;
               month_in = in_word_ff.load_month;
               day_in   = in_word_ff.load_day;
               hour_in  = in_word_ff.load_hour;
               min_in   = in_word_ff.load_minute;
               sec_in   = in_word_ff.load_second;
               run_in   = 1'b1;
            end
            OP_STOP: begin
               run_in = 1'b0;
            end
            OP_RUN: begin
               run_in = 1'b1;
            end
            default: begin
               run_in = run_ff;
            end
         endcase
      end
   end

   always_comb begin
      out_word_in.year_out    = year_in;
      out_word_in.month_out   = month_in;
      out_word_in.day_out     = day_in;
      out_word_in.hour_out    = hour_in;
      out_word_in.minute_out  = min_in;
      out_word_in.second_out  = sec_in;
      out_word_in.running_out = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sec_ff       <= 8'd0;
         min_ff       <= 8'd0;
         hour_ff      <= 8'd0;
         day_ff       <= 8'd0;
         month_ff     <= 8'd0;
         year_ff      <= 16'd0;
         run_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         run_ff       <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   `CCC_ASSERT(a_stop_clears_run, clock, reset,
      advance && in_word_ff.opcode == OP_STOP |=> !run_ff)
   `CCC_ASSERT(a_stopped_tick_holds, clock, reset,
      advance && in_word_ff.opcode == OP_TICK && !run_ff |=>
      $stable(sec_ff) && $stable(min_ff) && $stable(hour_ff) &&
      $stable(day_ff) && $stable(month_ff) && $stable(year_ff))
   `CCC_ASSERT(a_second_steps, clock, reset,
      advance && in_word_ff.opcode == OP_TICK && run_ff && sec_ff < SEC_LAST |=>
      sec_ff == $past(sec_ff) + 8'd1 && $stable(min_ff))
   `CCC_ASSERT(a_result_matches_state, clock, reset,
      $past(advance) |-> out_word_ff.second_out == sec_ff && out_word_ff.running_out == run_ff)
   `CCC_ASSERT_NEVER(a_state_moves_idle, clock, reset,
      !advance && (sec_in != sec_ff || run_in != run_ff))

endmodule

[sim/testbench.sv]
// testbench for calendar_clock_counter: directed table then random words,
// every response checked against a typed expected value or a calendar predictor kept in this file
// depends on ccc_pkg and the calendar_clock_counter rtl
module testbench;
   import ccc_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   typedef struct {
      req_type word;
      bit      typed_in;
      rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows[$];
   rsp_type   pending_readings[$];
   rsp_type   clock_state;
   int        mismatch_count = 0;
   int        send_idle_pct;
   int        recv_stall_pct;

   localparam rsp_type FROM_PREDICTOR = '0;
   localparam int RANDOM_WORDS = 617;

   calendar_clock_counter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic logic [7:0] month_limit(input logic [7:0] month,
                                              input logic [15:0] year);
      logic leap;
      leap = (year % 4000 != 0) &&
             ((year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0)));
      case (month)
         8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: begin
            month_limit = DAYS_LONG;
         end
         8'd2: begin
            month_limit = leap ? DAYS_LEAP : DAYS_FEB;
         end
         default: begin
            month_limit = DAYS_SHORT;
         end
      endcase
   endfunction

   // updates the predicted clock for one word and returns the new reading
   function automatic rsp_type advance_calendar(input req_type w);
      case (w.opcode)
         OP_TICK: begin
            if (clock_state.running_out) begin
               if (clock_state.second_out < SEC_LAST) begin
                  clock_state.second_out++;
               end else begin
                  clock_state.second_out = '0;
                  if (clock_state.minute_out < MIN_LAST) begin
                     clock_state.minute_out++;
                  end else begin
                     clock_state.minute_out = '0;
                     if (clock_state.hour_out < HOUR_LAST) begin
                        clock_state.hour_out++;
                     end else begin
                        clock_state.hour_out = '0;
                        if (clock_state.day_out <
                            month_limit(clock_state.month_out, clock_state.year_out)) begin
                           clock_state.day_out++;
                        end else begin
                           clock_state.day_out = 8'd1;
                           if (clock_state.month_out < MONTH_LAST) begin
                              clock_state.month_out++;
                           end else begin
                              clock_state.month_out = 8'd1;
                              clock_state.year_out++;
                           end
                        end
                     end
                  end
               end
            end
         end
         OP_LOAD: begin
            clock_state.year_out    = w.load_year;
            clock_state.month_out   = w.load_month;
            clock_state.day_out     = w.load_day;
            clock_state.hour_out    = w.load_hour;
            clock_state.minute_out  = w.load_minute;
            clock_state.second_out  = w.load_second;
            clock_state.running_out = 1'b1;
         end
         OP_STOP: begin
            clock_state.running_out = 1'b0;
         end
         default: begin
            clock_state.running_out = 1'b1;
         end
      endcase
      return clock_state;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int pick;
      w.load_year   = 16'($urandom);
      w.load_month  = 8'($urandom);
      w.load_day    = 8'($urandom);
      w.load_hour   = 8'($urandom);
      w.load_minute = 8'($urandom);
      w.load_second = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 72) begin
         w.opcode = OP_TICK;
      end else if (pick < 84) begin
         w.opcode = OP_LOAD;
      end else if (pick < 90) begin
         w.opcode = OP_STOP;
      end else begin
         w.opcode = OP_RUN;
      end
      // most loads land just short of a day rollover so a few ticks carry deep
      if (w.opcode == OP_LOAD && $urandom_range(3) != 0) begin
         case ($urandom_range(5))
            0: w.load_year = 16'($urandom_range(16383) * 4);
            1: w.load_year = 16'($urandom_range(655) * 100);
            2: w.load_year = 16'($urandom_range(163) * 400);
            3: w.load_year = 16'($urandom_range(16) * 4000);
            4: w.load_year = 16'hFFFF;
            default: ;
         endcase
         w.load_month  = 8'($urandom_range(1, 12));
         w.load_day    = 8'($urandom_range(27, 31));
         w.load_hour   = ($urandom_range(3) == 0) ? 8'($urandom_range(23)) : HOUR_LAST;
         w.load_minute = ($urandom_range(3) == 0) ? 8'($urandom_range(59)) : MIN_LAST;
         w.load_second = 8'($urandom_range(54, 59));
      end
      return w;
   endfunction

   // called just after a falling edge; returns just after a falling edge, once the word has been accepted
   task automatic send_word(input req_type w, input bit typed_in, input rsp_type want);
      rsp_type reading;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      reading = advance_calendar(w);
      pending_readings.push_back(typed_in ? want : reading);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_readings.size() != 0) @(negedge clock);
   endtask

   task automatic add_row(input req_type w, input bit typed_in, input rsp_type want);
      stim_row_type row;
      row.word     = w;
      row.typed_in = typed_in;
      row.want     = want;
      directed_rows.push_back(row);
   endtask

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("response word with none expected");
         end else begin
            want = pending_readings.pop_front();
            check_field("year", rsp_data.year_out, want.year_out);
            check_field("month", 16'(rsp_data.month_out), 16'(want.month_out));
            check_field("day", 16'(rsp_data.day_out), 16'(want.day_out));
            check_field("hour", 16'(rsp_data.hour_out), 16'(want.hour_out));
            check_field("minute", 16'(rsp_data.minute_out), 16'(want.minute_out));
            check_field("second", 16'(rsp_data.second_out), 16'(want.second_out));
            check_field("running", 16'(rsp_data.running_out), 16'(want.running_out));
         end
      end
   end

   initial begin
      int phase;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      send_idle_pct  = 17;
      recv_stall_pct = 49;
      clock_state    = '0;

      // stopped after reset, then run, then a tick with junk in the load fields
      add_row({OP_TICK, 56'h0}, 1'b1, {16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
      add_row({OP_RUN, 56'h0}, 1'b1, {16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
      add_row({OP_TICK, {56{1'b1}}}, 1'b1, {16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 1'b1});
      // last second of the last year wraps everything
      add_row({OP_LOAD, 16'd65535, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59}, 1'b1,
              {16'd65535, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 1'b1});
      add_row({OP_TICK, 56'h0}, 1'b1, {16'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1});
      // february in century, 400-year, 4000-year and plain leap years, then the end of a 30-day month
      add_row({OP_LOAD, 16'd2000, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      add_row({OP_LOAD, 16'd1900, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      add_row({OP_LOAD, 16'd4000, 8'd2, 8'd28, 8'd23, 8'd59, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      add_row({OP_LOAD, 16'd2024, 8'd2, 8'd29, 8'd23, 8'd59, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      add_row({OP_LOAD, 16'd2023, 8'd4, 8'd30, 8'd23, 8'd59, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      // month zero, every counter far out of range, day zero, minute out of range
      add_row({OP_LOAD, 16'd2023, 8'd0, 8'd30, 8'd23, 8'd59, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      add_row({OP_LOAD, 16'd500, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
              {16'd500, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      add_row({OP_LOAD, 16'd2023, 8'd6, 8'd0, 8'd23, 8'd59, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      add_row({OP_LOAD, 16'd2023, 8'd7, 8'd15, 8'd10, 8'd200, 8'd59}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);
      // a tick while stopped leaves the time alone
      add_row({OP_STOP, {56{1'b1}}}, 1'b0, FROM_PREDICTOR);
      add_row({OP_TICK, 56'h0}, 1'b0, FROM_PREDICTOR);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].word, directed_rows[i].typed_in, directed_rows[i].want);
      end
      wait_for_drain();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 17;
               recv_stall_pct = 49;
            end
            1: begin
               send_idle_pct  = 49;
               recv_stall_pct = 17;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_WORDS) send_word(random_word(), 1'b0, FROM_PREDICTOR);
         // sender holds off until every reading is back
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/ccc_pkg.sv
sv/calendar_clock_counter.sv
sim/testbench.sv
